// ===== hdl/lpl_pkg.sv =====
package lpl_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // Default build parameters.
  localparam int unsigned CHANNELS_DEF      = 2;
  localparam int unsigned DELAY_SAMPLES_DEF = 1;

  // Unity in Q1.16.
  localparam logic [LEVEL_W-1:0] UNITY_GAIN = 17'h10000;

  // Register reset values.
  localparam logic [COEF_W-1:0] THRESHOLD_RST = 16'd52429;
  localparam logic [COEF_W-1:0] ATTACK_RST    = 16'd19661;
  localparam logic [COEF_W-1:0] RELEASE_RST   = 16'd655;

  // Quotient bits produced by the divider, one per cycle.
  localparam int unsigned DIV_STEPS = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2
  } cfg_reg_t;

  // Input beat.
  typedef struct packed {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic                       channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_t;

endpackage

// ===== hdl/lookahead_peak_limiter.sv =====
// Each beat passes the peak, target, gain, multiply and saturate states in order; when the
// target gain needs the divide, the 16-step restoring divider runs between target and gain.
// A new beat is taken only in the idle state, once the last result has been registered.
// The delay line sits in one synchronous memory; per-channel wrap flags make unwritten
// slots read as zero, so there is no clearing pass after reset.
// Reset (synchronous, active low) restores registers, unity gain, zero peak, pointers, wrap flags.
module lookahead_peak_limiter #(
  parameter int unsigned CHANNELS      = lpl_pkg::CHANNELS_DEF,
  parameter int unsigned DELAY_SAMPLES = lpl_pkg::DELAY_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lpl_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lpl_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lpl_pkg::COEF_W-1:0]     cfg_wdata
);
  import lpl_pkg::*;

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PTR_W  = (DELAY_SAMPLES > 1) ? $clog2(DELAY_SAMPLES) : 1;
  localparam int unsigned DEPTH  = CHANNELS * DELAY_SAMPLES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_TGT,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_SAT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [COEF_W-1:0] threshold_r;
  logic [COEF_W-1:0] attack_r;
  logic [COEF_W-1:0] release_r;

  // Shared follower state.
  logic [LEVEL_W-1:0] peak_r;
  logic [LEVEL_W-1:0] gain_r;
  logic [LEVEL_W-1:0] tgt_r;

  // Per-channel delay line control.
  logic [PTR_W-1:0] ptr_r [CHANNELS];
  logic             wrap_r [CHANNELS];

  // Per-item working registers.
  logic                       chan_r;
  logic [CH_W-1:0]            ch_idx_r;
  logic [SAMPLE_W-1:0]        samp_r;
  logic [LEVEL_W-1:0]         mag_r;
  logic [ADDR_W-1:0]          addr_r;
  logic                       slot_ok_r;
  logic signed [SAMPLE_W-1:0] dly_r;
  logic [LEVEL_W:0]           rem_r;
  logic [DIV_STEPS-1:0]       quo_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [33:0]         prod_r;

  // Output register.
  logic out_valid_r;
  out_t out_data_r;

  // Delay memory.
  logic [SAMPLE_W-1:0] dly_mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                mem_we;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Channel select and delay line address of the incoming beat.
  logic [CH_W-1:0]         in_ch_idx;
  logic [ADDR_W-1:0]       in_addr;
  logic signed [16:0]      in_ext;
  logic signed [16:0]      in_abs;

  always_comb begin
    in_ch_idx = (CHANNELS == 1) ? '0 : CH_W'(in_data.channel);
    in_addr   = ADDR_W'(in_ch_idx) * ADDR_W'(DELAY_SAMPLES) + ADDR_W'(ptr_r[in_ch_idx]);
    in_ext    = {in_data.sample_in[SAMPLE_W-1], in_data.sample_in};
    in_abs    = in_ext[16] ? -in_ext : in_ext;
  end

  // Shared smoothing unit: old + ((c * (target - old) + 2^15) >>> 16).
  logic [LEVEL_W-1:0] sm_old;
  logic [LEVEL_W-1:0] sm_tgt;
  logic [COEF_W-1:0]  sm_c;
  logic signed [17:0] sm_diff;
  logic signed [34:0] sm_prod;
  logic signed [34:0] sm_acc;
  logic signed [18:0] sm_sum;
  logic [LEVEL_W-1:0] sm_res;

  always_comb begin
    if (state_r == ST_PEAK) begin
      sm_old = peak_r;
      sm_tgt = mag_r;
      sm_c   = (mag_r > peak_r) ? attack_r : release_r;
    end else begin
      sm_old = gain_r;
      sm_tgt = tgt_r;
      sm_c   = (gain_r > tgt_r) ? attack_r : release_r;
    end
    sm_diff = $signed({1'b0, sm_tgt}) - $signed({1'b0, sm_old});
    sm_prod = $signed({1'b0, sm_c}) * sm_diff;
    sm_acc  = sm_prod + 35'sd32768;
    sm_sum  = $signed({2'b00, sm_old}) + sm_acc[34:16];
    sm_res  = sm_sum[LEVEL_W-1:0];
  end

  // One restoring divide step.
  logic [LEVEL_W:0]     div_shift;
  logic                 div_ge;
  logic [LEVEL_W:0]     div_rem;
  logic [DIV_STEPS-1:0] div_quo;

  always_comb begin
    div_shift = {rem_r[LEVEL_W-1:0], 1'b0};
    div_ge    = (div_shift >= {1'b0, peak_r});
    div_rem   = div_ge ? (div_shift - {1'b0, peak_r}) : div_shift;
    div_quo   = {quo_r[DIV_STEPS-2:0], div_ge};
  end

  // Output rounding and saturation.
  logic signed [33:0] rnd_sum;
  logic signed [17:0] rnd_y;
  logic [SAMPLE_W-1:0] sat_y;

  always_comb begin
    rnd_sum = prod_r + 34'sd32768;
    rnd_y   = rnd_sum[33:16];
    if (rnd_y > 18'sd32767) begin
      sat_y = 16'h7fff;
    end else if (rnd_y < -18'sd32768) begin
      sat_y = 16'h8000;
    end else begin
      sat_y = rnd_y[SAMPLE_W-1:0];
    end
  end

  assign mem_we = (state_r == ST_PEAK);

  // Delay memory: registered read at acceptance, write-back of the new sample in the next cycle.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rd_data_r <= dly_mem[in_addr];
    end
    if (mem_we) begin
      dly_mem[addr_r] <= samp_r;
    end
  end

  // Sequencer, follower state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      threshold_r <= THRESHOLD_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      peak_r      <= '0;
      gain_r      <= UNITY_GAIN;
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_r[i]  <= '0;
        wrap_r[i] <= 1'b0;
      end
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_idx)
          REG_THRESHOLD: threshold_r <= cfg_wdata;
          REG_ATTACK:    attack_r    <= cfg_wdata;
          REG_RELEASE:   release_r   <= cfg_wdata;
          default: ;
        endcase
      end

      // The result leaves on its beat; a result finished in the same cycle takes its place.
      if (out_valid_r && out_ready && (state_r != ST_SAT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            chan_r    <= in_data.channel;
            ch_idx_r  <= in_ch_idx;
            samp_r    <= in_data.sample_in;
            mag_r     <= {in_abs[15:0], 1'b0};
            addr_r    <= in_addr;
            slot_ok_r <= wrap_r[in_ch_idx];
            state_r   <= ST_PEAK;
          end
        end
        ST_PEAK: begin
          // Slots not yet written since reset read as silence.
          dly_r  <= slot_ok_r ? $signed(rd_data_r) : '0;
          peak_r <= sm_res;
          if (ptr_r[ch_idx_r] == PTR_W'(DELAY_SAMPLES - 1)) begin
            ptr_r[ch_idx_r]  <= '0;
            wrap_r[ch_idx_r] <= 1'b1;
          end else begin
            ptr_r[ch_idx_r] <= ptr_r[ch_idx_r] + 1'b1;
          end
          state_r <= ST_TGT;
        end
        ST_TGT: begin
          // Unity gain for a zero peak or a peak within the threshold.
          if ((peak_r == '0) || ({1'b0, threshold_r} >= peak_r)) begin
            tgt_r   <= UNITY_GAIN;
            state_r <= ST_GAIN;
          end else begin
            rem_r   <= {2'b00, threshold_r};
            quo_r   <= '0;
            cnt_r   <= CNT_W'(DIV_STEPS - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= div_rem;
          quo_r <= div_quo;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            tgt_r   <= {1'b0, div_quo};
            state_r <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          gain_r  <= sm_res;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= $signed({1'b0, gain_r}) * dly_r;
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.channel_out <= chan_r;
            out_data_r.sample_out  <= sat_y;
            out_valid_r            <= 1'b1;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpl_pkg::*;

  localparam int unsigned CHANNELS      = CHANNELS_DEF;
  localparam int unsigned DELAY_SAMPLES = DELAY_SAMPLES_DEF;
  localparam real         CLK_PERIOD    = 10.0;

  // Index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Cycles to let the divider finish after the last result, and the stall limit.
  localparam int unsigned DRAIN_CYCLES   = 25;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned BEATS_PER_PHASE = 229;

  // Receiver stall patterns.
  localparam int unsigned RX_FREE     = 0;
  localparam int unsigned RX_COIN     = 1;
  localparam int unsigned RX_SPARSE   = 2;
  localparam int unsigned RX_PERIODIC = 3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  lookahead_peak_limiter #(
    .CHANNELS     (CHANNELS),
    .DELAY_SAMPLES(DELAY_SAMPLES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Limiter state as the testbench sees it.
  logic [COEF_W-1:0]   lim_threshold;
  logic [COEF_W-1:0]   lim_attack;
  logic [COEF_W-1:0]   lim_release;
  longint              lim_peak;
  longint              lim_gain;
  logic [SAMPLE_W-1:0] delay_line [CHANNELS][DELAY_SAMPLES];
  int unsigned         delay_ptr [CHANNELS];

  out_t        limited_q[$];
  out_t        want;
  int unsigned errors       = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_requests = 0;

  function automatic longint smooth_level(longint cur, longint target, longint coeff);
    return ((65536 - coeff) * cur + coeff * target + 32768) >> 16;
  endfunction

  // Advances the limiter state by one sample and returns the limited delayed sample.
  function automatic out_t predict_limited(in_t beat);
    longint      s;
    longint      mag;
    longint      coeff;
    longint      target;
    longint      delayed;
    longint      y;
    int unsigned ch;
    int unsigned ptr;
    out_t        result;
    s   = $signed(beat.sample_in);
    mag = (s < 0 ? -s : s) * 2;

    // Peak follower, attack on a rising magnitude.
    coeff    = (mag > lim_peak) ? longint'(lim_attack) : longint'(lim_release);
    lim_peak = smooth_level(lim_peak, mag, coeff);

    // Target gain; a zero peak or one under the threshold leaves unity.
    if (lim_peak == 0 || longint'(lim_threshold) >= lim_peak) begin
      target = 65536;
    end else begin
      target = (longint'(lim_threshold) << 16) / lim_peak;
    end
    coeff    = (lim_gain > target) ? longint'(lim_attack) : longint'(lim_release);
    lim_gain = smooth_level(lim_gain, target, coeff);

    // Swap the new sample into the channel's delay line.
    ch  = beat.channel % CHANNELS;
    ptr = delay_ptr[ch];
    delayed = $signed(delay_line[ch][ptr]);
    delay_line[ch][ptr] = beat.sample_in;
    delay_ptr[ch] = (ptr + 1 >= DELAY_SAMPLES) ? 0 : ptr + 1;

    // Apply the gain with round half up, then saturate.
    y = (lim_gain * delayed + 32768) >>> 16;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    result.channel_out = beat.channel;
    result.sample_out  = 16'(y);
    return result;
  endfunction

  task automatic reset_limiter_state();
    lim_threshold = THRESHOLD_RST;
    lim_attack    = ATTACK_RST;
    lim_release   = RELEASE_RST;
    lim_peak      = 0;
    lim_gain      = 65536;
    foreach (delay_line[c, i]) delay_line[c][i] = '0;
    foreach (delay_ptr[c]) delay_ptr[c] = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: lim_threshold = value;
      REG_ATTACK:    lim_attack    = value;
      REG_RELEASE:   lim_release   = value;
      default: ;
    endcase
  endtask

  // Offers one beat after an optional gap and records its expected result once taken.
  task automatic send_beat(input in_t beat, input int unsigned gap, input bit typed,
                           input logic [SAMPLE_W-1:0] typed_sample);
    out_t result;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    result = predict_limited(beat);
    if (typed) result.sample_out = typed_sample;
    limited_q.push_back(result);
  endtask

  // Stops offering and waits for every pending result.
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (limited_q.size() != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly loud and quiet passages so the limiter engages and releases.
  function automatic in_t random_beat();
    in_t               beat;
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($urandom);
      4, 5: v = $urandom_range(0, 1) ? 16'($urandom_range(24576, 32767))
                                     : 16'(32'd0 - $urandom_range(24577, 32768));
      6, 7: v = 16'($urandom_range(0, 2047) - 1024);
      8: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7fff;
          1: v = 16'h8000;
          2: v = 16'h0000;
          3: v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
      default: v = 16'($urandom) & 16'h00ff;
    endcase
    beat.channel   = 1'($urandom_range(0, 1));
    beat.sample_in = v;
    return beat;
  endfunction

  // Random traffic in bursts; optionally pauses once for all results to drain.
  task automatic run_traffic(input int unsigned count, input int pause_at);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        gap = 0;
      end
      send_beat(random_beat(), gap, 1'b0, '0);
      burst_left--;
    end
  endtask

  // Receiver: changes its stall pattern now and then, and serves long holds on request.
  int unsigned rx_mode      = RX_FREE;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_served = 0;

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(RX_FREE, RX_PERIODIC);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= rx_mode_left[2];
      endcase
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (limited_q.size() == 0) begin
        $display("%0t: unexpected result beat channel %0d sample %0d", $time,
                 out_data.channel_out, $signed(out_data.sample_out));
        errors++;
      end else begin
        want = limited_q.pop_front();
        if (out_data.channel_out !== want.channel_out) begin
          $display("%0t: channel_out expected %0d got %0d", $time,
                   want.channel_out, out_data.channel_out);
          errors++;
        end
        if (out_data.sample_out !== want.sample_out) begin
          $display("%0t: sample_out expected %0d got %0d", $time,
                   $signed(want.sample_out), $signed(out_data.sample_out));
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
      $display("lookahead_peak_limiter verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  typedef struct {
    logic                channel;
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    logic [SAMPLE_W-1:0] expected;
  } directed_row_t;

  typedef struct {
    logic [COEF_W-1:0] threshold;
    logic [COEF_W-1:0] attack;
    logic [COEF_W-1:0] release_c;
    bit                draw_regs;
  } phase_row_t;

  // Directed samples; the first beat on each channel reads an empty delay line.
  directed_row_t directed_rows[] = '{
    '{1'b0, 16'h0000, 1'b1, 16'h0000},
    '{1'b1, 16'h7fff, 1'b1, 16'h0000},
    '{1'b0, 16'h8000, 1'b1, 16'h0000},
    '{1'b1, 16'h8000, 1'b0, 16'h0000},
    '{1'b0, 16'h7fff, 1'b0, 16'h0000},
    '{1'b0, 16'hffff, 1'b0, 16'h0000},
    '{1'b1, 16'h0001, 1'b0, 16'h0000},
    '{1'b0, 16'h8000, 1'b0, 16'h0000},
    '{1'b0, 16'h8000, 1'b0, 16'h0000},
    '{1'b1, 16'h7fff, 1'b0, 16'h0000},
    '{1'b1, 16'h0000, 1'b0, 16'h0000},
    '{1'b0, 16'h4000, 1'b0, 16'h0000},
    '{1'b1, 16'hc000, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 1'b0, 16'h0000},
    '{1'b1, 16'h5555, 1'b0, 16'h0000},
    '{1'b0, 16'haaaa, 1'b0, 16'h0000},
    '{1'b1, 16'h7fff, 1'b0, 16'h0000},
    '{1'b0, 16'h8001, 1'b0, 16'h0000}
  };

  // Register settings per phase: zero threshold, all maximum, frozen smoothing, a mix, reset values, random draws.
  phase_row_t phase_rows[] = '{
    '{16'd0,     16'd19661, 16'd655,   1'b0},
    '{16'hffff,  16'hffff,  16'hffff,  1'b0},
    '{16'd0,     16'd0,     16'd0,     1'b0},
    '{16'd26214, 16'hffff,  16'd0,     1'b0},
    '{16'd52429, 16'd19661, 16'd655,   1'b0},
    '{16'd0,     16'd0,     16'd0,     1'b1},
    '{16'd0,     16'd0,     16'd0,     1'b1},
    '{16'd0,     16'd0,     16'd0,     1'b1}
  };

  initial begin
    in_t        beat;
    phase_row_t setting;
    reset_limiter_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A write past the register list must leave everything as it was.
    write_reg(REG_SPARE, 16'($urandom));

    foreach (directed_rows[i]) begin
      beat.channel   = directed_rows[i].channel;
      beat.sample_in = directed_rows[i].sample;
      send_beat(beat, $urandom_range(0, 3), directed_rows[i].typed,
                directed_rows[i].expected);
    end
    quiesce();

    foreach (phase_rows[p]) begin
      setting = phase_rows[p];
      if (setting.draw_regs) begin
        setting.threshold = 16'($urandom);
        setting.attack    = 16'($urandom);
        setting.release_c = 16'($urandom);
      end
      write_reg(REG_THRESHOLD, setting.threshold);
      write_reg(REG_ATTACK, setting.attack);
      write_reg(REG_RELEASE, setting.release_c);
      // The first phase starts with a long receiver hold to back up the input.
      if (p == 0) hold_requests++;
      run_traffic(BEATS_PER_PHASE, (p == 3) ? 100 : -1);
      quiesce();
    end

    if (limited_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, limited_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("lookahead_peak_limiter verification clean");
    end else begin
      $display("lookahead_peak_limiter verification failed");
    end
    $finish;
  end

endmodule
